### hw/rtl/pd_drive_distance_controller_assert.svh
// assertion macros for the pd drive distance controller checker
// needs nothing else; included by the checker file only
`ifndef PD_DRIVE_DISTANCE_CONTROLLER_ASSERT_SVH
`define PD_DRIVE_DISTANCE_CONTROLLER_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define PDDC_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pddc same-cycle check failed");

// condition must hold in the cycle after the trigger
`define PDDC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pddc next-cycle check failed");

`endif

### hw/rtl/pddc_pkg.sv
// shared widths, register indexes, reset values and constants
// used by the interfaces, the controller and its checker
`default_nettype none

package pddc_pkg;

    // field widths
    localparam int DIST_W    = 11;
    localparam int POS_W     = 24;
    localparam int DRIVE_W   = 8;
    localparam int GAIN_W    = 16;
    localparam int TPU_W     = 8;
    localparam int POWER_W   = 7;
    localparam int TOL_W     = 12;
    localparam int TIMEOUT_W = 10;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISTANCE_GAIN   = 3'd0,
        CFG_DERIVATIVE_GAIN = 3'd1,
        CFG_SIDE_GAIN       = 3'd2,
        CFG_TICKS_PER_UNIT  = 3'd3,
        CFG_MIN_POWER       = 3'd4,
        CFG_SIDE_LIMIT      = 3'd5,
        CFG_TOLERANCE       = 3'd6,
        CFG_TIMEOUT_TICKS   = 3'd7
    } t_cfg_idx;

    // word opcodes
    typedef enum logic {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    // register reset values
    localparam logic [GAIN_W-1:0]    DISTANCE_GAIN_RST   = 16'd28;
    localparam logic [GAIN_W-1:0]    DERIVATIVE_GAIN_RST = 16'd154;
    localparam logic [GAIN_W-1:0]    SIDE_GAIN_RST       = 16'd230;
    localparam logic [TPU_W-1:0]     TICKS_PER_UNIT_RST  = 8'd28;
    localparam logic [POWER_W-1:0]   MIN_POWER_RST       = 7'd20;
    localparam logic [POWER_W-1:0]   SIDE_LIMIT_RST      = 7'd63;
    localparam logic [TOL_W-1:0]     TOLERANCE_RST       = 12'd30;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_TICKS_RST   = 10'd250;

    // internal arithmetic widths
    localparam int TGT_W   = 20;  // distance times ticks per unit
    localparam int ERR_W   = 25;  // target minus position, left minus right
    localparam int DER_W   = 26;  // error difference
    localparam int MAG_W   = 25;  // magnitudes fed to the gain multipliers
    localparam int PMAG_W  = 24;  // position magnitude
    localparam int PROD_W  = MAG_W + GAIN_W;
    localparam int Q8_SH   = 8;   // gains are Q8.8
    localparam int TERM_W  = PROD_W - Q8_SH;
    localparam int BASE_W  = 36;
    localparam int SIDE_W  = POWER_W + 1;
    localparam int LR_W    = BASE_W + 1;

    // divide by three: floor(x / 3) == (x * 0xAAAAAB) >> 25 for x below 2^25
    localparam int                 DIV3_SHIFT = 25;
    localparam logic [PMAG_W-1:0]  DIV3_RECIP = 24'hAAAAAB;
    localparam int                 DIV_W      = 2 * PMAG_W;
    localparam int                 Q_W        = 22;

    localparam int DRIVE_MAX = 127;

endpackage

`default_nettype wire

### hw/rtl/pddc_ifs.sv
// valid/ready channel interfaces: sample word in, drive word out, config writes
// depends on pddc_pkg for field widths
`default_nettype none

interface pddc_item_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   op;
    logic signed [pddc_pkg::DIST_W-1:0]     target_distance;
    logic                                   backward;
    logic signed [pddc_pkg::POS_W-1:0]      mean_position;
    logic signed [pddc_pkg::POS_W-1:0]      left_count;
    logic signed [pddc_pkg::POS_W-1:0]      right_count;

    modport source (
        output valid, op, target_distance, backward, mean_position, left_count,
               right_count,
        input  ready
    );
    modport sink (
        input  valid, op, target_distance, backward, mean_position, left_count,
               right_count,
        output ready
    );
endinterface

interface pddc_result_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [pddc_pkg::DRIVE_W-1:0]    left_drive;
    logic signed [pddc_pkg::DRIVE_W-1:0]    right_drive;
    logic                                   done_res;
    logic                                   timed_out;

    modport source (
        output valid, left_drive, right_drive, done_res, timed_out,
        input  ready
    );
    modport sink (
        input  valid, left_drive, right_drive, done_res, timed_out,
        output ready
    );
endinterface

interface pddc_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [pddc_pkg::CFG_IDX_W-1:0]         index;
    logic [pddc_pkg::CFG_DATA_W-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/pd_drive_distance_controller.sv
// PD drive-distance controller with ramp-limited drive output. Takes one word per clock
// cycle while the output is not stalled, and returns exactly one result word per input
// word, in the order the words were taken. A start word loads the target and clears
// the tick count, and its result is all zero; a tick word while no move is running also
// gives an all-zero result. The controller state (target, previous error, tick count,
// moving flag) is read and updated in the first stage, so a tick may directly follow a
// start or another tick. The gain multiplies and the divide by three share one stage;
// stalls at the output back up stage by stage, with bubbles squeezed out.
// Configuration writes are always accepted and must only be made while no move is busy.
// Depends on pddc_pkg and the interfaces in pddc_ifs.sv.
`default_nettype none

module pd_drive_distance_controller (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pddc_cfg_if.sink       i_cfg,
    pddc_item_if.sink      i_item,
    pddc_result_if.source  o_result
);

    // configuration registers
    logic [pddc_pkg::GAIN_W-1:0]    r_distance_gain;
    logic [pddc_pkg::GAIN_W-1:0]    r_derivative_gain;
    logic [pddc_pkg::GAIN_W-1:0]    r_side_gain;
    logic [pddc_pkg::TPU_W-1:0]     r_ticks_per_unit;
    logic [pddc_pkg::POWER_W-1:0]   r_min_power;
    logic [pddc_pkg::POWER_W-1:0]   r_side_limit;
    logic [pddc_pkg::TOL_W-1:0]     r_tolerance;
    logic [pddc_pkg::TIMEOUT_W-1:0] r_timeout_ticks;

    // move state
    logic signed [pddc_pkg::TGT_W-1:0] r_target;
    logic signed [pddc_pkg::ERR_W-1:0] r_prev_err;
    logic                              r_have_prev;
    logic [pddc_pkg::TIMEOUT_W-1:0]    r_tick_count;
    logic                              r_moving;
    logic                              r_going_back;

    // stage valids and advance enables
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_out_valid;
    logic en1, en2, en3, en4, en5, en_out;

    // stage 1: input register
    logic                                r_s1_op;
    logic signed [pddc_pkg::DIST_W-1:0]  r_s1_dist;
    logic                                r_s1_back;
    logic signed [pddc_pkg::POS_W-1:0]   r_s1_pos;
    logic signed [pddc_pkg::POS_W-1:0]   r_s1_left;
    logic signed [pddc_pkg::POS_W-1:0]   r_s1_right;

    logic signed [pddc_pkg::TGT_W-1:0]     s1_dist_x, s1_tpu_x, n_target;
    logic signed [pddc_pkg::ERR_W-1:0]     s1_err, s1_diff, s1_tol;
    logic signed [pddc_pkg::DER_W-1:0]     s1_der;
    logic [pddc_pkg::TIMEOUT_W-1:0]        n_tick_count;
    logic                                  s1_start, s1_live, s1_near, s1_expired;

    // stage 2: signed differences
    logic                              r_s2_live, r_s2_done, r_s2_tout, r_s2_back;
    logic signed [pddc_pkg::ERR_W-1:0] r_s2_err, r_s2_diff;
    logic signed [pddc_pkg::DER_W-1:0] r_s2_der;
    logic signed [pddc_pkg::POS_W-1:0] r_s2_pos;

    logic [pddc_pkg::MAG_W-1:0]  s2_err_mag, s2_der_mag, s2_diff_mag;
    logic [pddc_pkg::PMAG_W-1:0] s2_pos_mag;

    // stage 3: magnitudes and signs
    logic                              r_s3_live, r_s3_done, r_s3_tout, r_s3_back;
    logic [pddc_pkg::MAG_W-1:0]        r_s3_err_mag, r_s3_der_mag, r_s3_diff_mag;
    logic [pddc_pkg::PMAG_W-1:0]       r_s3_pos_mag;
    logic                              r_s3_err_neg, r_s3_err_nz, r_s3_der_neg, r_s3_diff_neg;

    logic [pddc_pkg::PROD_W-1:0] s3_p_dist, s3_p_der, s3_p_side;
    logic [pddc_pkg::DIV_W-1:0]  s3_div;

    // stage 4: truncated products
    logic                               r_s4_live, r_s4_done, r_s4_tout, r_s4_back;
    logic [pddc_pkg::TERM_W-1:0]        r_s4_pe, r_s4_pd, r_s4_ps;
    logic                               r_s4_err_neg, r_s4_err_nz, r_s4_der_neg, r_s4_diff_neg;
    logic [pddc_pkg::Q_W-1:0]           r_s4_q;

    logic signed [pddc_pkg::BASE_W-1:0] s4_pe, s4_pd, s4_min, s4_base;
    logic [pddc_pkg::POWER_W-1:0]       s4_side_mag, s4_ramp;
    logic signed [pddc_pkg::SIDE_W-1:0] s4_side;
    logic [pddc_pkg::POWER_W:0]         s4_ramp_sum;

    // stage 5: base drive, side term, ramp
    logic                               r_s5_live, r_s5_done, r_s5_tout, r_s5_back;
    logic signed [pddc_pkg::BASE_W-1:0] r_s5_base;
    logic signed [pddc_pkg::SIDE_W-1:0] r_s5_side;
    logic [pddc_pkg::POWER_W-1:0]       r_s5_ramp;

    logic signed [pddc_pkg::LR_W-1:0]    s5_left, s5_right;
    logic signed [pddc_pkg::DRIVE_W-1:0] s5_left_drv, s5_right_drv;

    // output register
    logic signed [pddc_pkg::DRIVE_W-1:0] r_out_left, r_out_right;
    logic                                r_out_done, r_out_tout;

    // ramp cap above, mirrored cap below when backing up, then the motor range
    function automatic logic signed [pddc_pkg::DRIVE_W-1:0] drive_limit(
        input logic signed [pddc_pkg::LR_W-1:0] v,
        input logic [pddc_pkg::POWER_W-1:0]     ramp,
        input logic                             back
    );
        logic signed [pddc_pkg::LR_W-1:0] hi;
        logic signed [pddc_pkg::LR_W-1:0] lim;
        logic signed [pddc_pkg::LR_W-1:0] x;
        hi  = $signed(pddc_pkg::LR_W'(ramp));
        lim = -$signed(pddc_pkg::LR_W'(pddc_pkg::DRIVE_MAX));
        x   = v;
        if (x > hi) begin
            x = hi;
        end
        if (back && (x < -hi)) begin
            x = -hi;
        end
        if (x < lim) begin
            x = lim;
        end
        return x[pddc_pkg::DRIVE_W-1:0];
    endfunction

    // configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_distance_gain   <= pddc_pkg::DISTANCE_GAIN_RST;
            r_derivative_gain <= pddc_pkg::DERIVATIVE_GAIN_RST;
            r_side_gain       <= pddc_pkg::SIDE_GAIN_RST;
            r_ticks_per_unit  <= pddc_pkg::TICKS_PER_UNIT_RST;
            r_min_power       <= pddc_pkg::MIN_POWER_RST;
            r_side_limit      <= pddc_pkg::SIDE_LIMIT_RST;
            r_tolerance       <= pddc_pkg::TOLERANCE_RST;
            r_timeout_ticks   <= pddc_pkg::TIMEOUT_TICKS_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                pddc_pkg::CFG_DISTANCE_GAIN:   r_distance_gain   <= i_cfg.data;
                pddc_pkg::CFG_DERIVATIVE_GAIN: r_derivative_gain <= i_cfg.data;
                pddc_pkg::CFG_SIDE_GAIN:       r_side_gain       <= i_cfg.data;
                pddc_pkg::CFG_TICKS_PER_UNIT:
                    r_ticks_per_unit <= i_cfg.data[pddc_pkg::TPU_W-1:0];
                pddc_pkg::CFG_MIN_POWER:
                    r_min_power <= i_cfg.data[pddc_pkg::POWER_W-1:0];
                pddc_pkg::CFG_SIDE_LIMIT:
                    r_side_limit <= i_cfg.data[pddc_pkg::POWER_W-1:0];
                pddc_pkg::CFG_TOLERANCE:
                    r_tolerance <= i_cfg.data[pddc_pkg::TOL_W-1:0];
                pddc_pkg::CFG_TIMEOUT_TICKS:
                    r_timeout_ticks <= i_cfg.data[pddc_pkg::TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // stage advance: a stage moves on when the next one is empty or moving on
    assign en_out       = !r_out_valid || o_result.ready;
    assign en5          = !r_v5 || en_out;
    assign en4          = !r_v4 || en5;
    assign en3          = !r_v3 || en4;
    assign en2          = !r_v2 || en3;
    assign en1          = !r_v1 || en2;
    assign i_item.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en1)    r_v1        <= i_item.valid;
            if (en2)    r_v2        <= r_v1;
            if (en3)    r_v3        <= r_v2;
            if (en4)    r_v4        <= r_v3;
            if (en5)    r_v5        <= r_v4;
            if (en_out) r_out_valid <= r_v5;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (en1 && i_item.valid) begin
            r_s1_op    <= i_item.op;
            r_s1_dist  <= i_item.target_distance;
            r_s1_back  <= i_item.backward;
            r_s1_pos   <= i_item.mean_position;
            r_s1_left  <= i_item.left_count;
            r_s1_right <= i_item.right_count;
        end
    end

    // stage 1: target load, error, derivative, side difference, end of move
    assign s1_start  = (r_s1_op == pddc_pkg::OP_START);
    assign s1_live   = !s1_start && r_moving;
    assign s1_dist_x = pddc_pkg::TGT_W'(r_s1_dist);
    assign s1_tpu_x  = $signed(pddc_pkg::TGT_W'(r_ticks_per_unit));
    assign n_target  = s1_dist_x * s1_tpu_x;

    assign s1_err  = pddc_pkg::ERR_W'(r_target) - pddc_pkg::ERR_W'(r_s1_pos);
    assign s1_diff = pddc_pkg::ERR_W'(r_s1_left) - pddc_pkg::ERR_W'(r_s1_right);
    assign s1_der  = r_have_prev
                   ? (pddc_pkg::DER_W'(s1_err) - pddc_pkg::DER_W'(r_prev_err))
                   : '0;

    assign s1_tol     = $signed(pddc_pkg::ERR_W'(r_tolerance));
    assign s1_near    = (s1_err <= s1_tol) && (s1_err >= -s1_tol);
    assign n_tick_count = (r_tick_count == '1) ? r_tick_count
                        : r_tick_count + pddc_pkg::TIMEOUT_W'(1);
    assign s1_expired = (n_tick_count >= r_timeout_ticks);

    // controller state, updated as a word leaves stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target     <= '0;
            r_have_prev  <= 1'b0;
            r_tick_count <= '0;
            r_moving     <= 1'b0;
            r_going_back <= 1'b0;
        end else if (r_v1 && en2) begin
            if (s1_start) begin
                r_target     <= n_target;
                r_going_back <= r_s1_back;
                r_tick_count <= '0;
                r_have_prev  <= 1'b0;
                r_moving     <= 1'b1;
            end else if (s1_live) begin
                r_have_prev  <= 1'b1;
                r_tick_count <= n_tick_count;
                if (s1_near || s1_expired) begin
                    r_moving <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1 && en2 && s1_live) begin
            r_prev_err <= s1_err;
        end
    end

    // stage 2 register
    always_ff @(posedge i_clk) begin
        if (r_v1 && en2) begin
            r_s2_live <= s1_live;
            r_s2_done <= s1_live && (s1_near || s1_expired);
            r_s2_tout <= s1_live && !s1_near && s1_expired;
            r_s2_back <= r_going_back;
            r_s2_err  <= s1_err;
            r_s2_der  <= s1_der;
            r_s2_diff <= s1_diff;
            r_s2_pos  <= r_s1_pos;
        end
    end

    // stage 2: magnitudes
    assign s2_err_mag  = r_s2_err[pddc_pkg::ERR_W-1]
                       ? pddc_pkg::MAG_W'(-r_s2_err) : pddc_pkg::MAG_W'(r_s2_err);
    assign s2_der_mag  = r_s2_der[pddc_pkg::DER_W-1]
                       ? pddc_pkg::MAG_W'(-r_s2_der) : pddc_pkg::MAG_W'(r_s2_der);
    assign s2_diff_mag = r_s2_diff[pddc_pkg::ERR_W-1]
                       ? pddc_pkg::MAG_W'(-r_s2_diff) : pddc_pkg::MAG_W'(r_s2_diff);
    assign s2_pos_mag  = r_s2_pos[pddc_pkg::POS_W-1]
                       ? pddc_pkg::PMAG_W'(-r_s2_pos) : pddc_pkg::PMAG_W'(r_s2_pos);

    // stage 3 register
    always_ff @(posedge i_clk) begin
        if (r_v2 && en3) begin
            r_s3_live     <= r_s2_live;
            r_s3_done     <= r_s2_done;
            r_s3_tout     <= r_s2_tout;
            r_s3_back     <= r_s2_back;
            r_s3_err_mag  <= s2_err_mag;
            r_s3_der_mag  <= s2_der_mag;
            r_s3_diff_mag <= s2_diff_mag;
            r_s3_pos_mag  <= s2_pos_mag;
            r_s3_err_neg  <= r_s2_err[pddc_pkg::ERR_W-1];
            r_s3_err_nz   <= (r_s2_err != '0);
            r_s3_der_neg  <= r_s2_der[pddc_pkg::DER_W-1];
            r_s3_diff_neg <= r_s2_diff[pddc_pkg::ERR_W-1];
        end
    end

    // stage 3: gain products on magnitudes, position divided by three
    assign s3_p_dist = pddc_pkg::PROD_W'(r_s3_err_mag) * pddc_pkg::PROD_W'(r_distance_gain);
    assign s3_p_der  = pddc_pkg::PROD_W'(r_s3_der_mag) * pddc_pkg::PROD_W'(r_derivative_gain);
    assign s3_p_side = pddc_pkg::PROD_W'(r_s3_diff_mag) * pddc_pkg::PROD_W'(r_side_gain);
    assign s3_div    = pddc_pkg::DIV_W'(r_s3_pos_mag) * pddc_pkg::DIV_W'(pddc_pkg::DIV3_RECIP);

    // stage 4 register, products truncated toward zero
    always_ff @(posedge i_clk) begin
        if (r_v3 && en4) begin
            r_s4_live     <= r_s3_live;
            r_s4_done     <= r_s3_done;
            r_s4_tout     <= r_s3_tout;
            r_s4_back     <= r_s3_back;
            r_s4_pe       <= s3_p_dist[pddc_pkg::PROD_W-1:pddc_pkg::Q8_SH];
            r_s4_pd       <= s3_p_der[pddc_pkg::PROD_W-1:pddc_pkg::Q8_SH];
            r_s4_ps       <= s3_p_side[pddc_pkg::PROD_W-1:pddc_pkg::Q8_SH];
            r_s4_err_neg  <= r_s3_err_neg;
            r_s4_err_nz   <= r_s3_err_nz;
            r_s4_der_neg  <= r_s3_der_neg;
            r_s4_diff_neg <= r_s3_diff_neg;
            r_s4_q        <= s3_div[pddc_pkg::DIV3_SHIFT +: pddc_pkg::Q_W];
        end
    end

    // stage 4: signed terms and base drive
    assign s4_pe  = r_s4_err_neg ? -$signed(pddc_pkg::BASE_W'(r_s4_pe))
                                 :  $signed(pddc_pkg::BASE_W'(r_s4_pe));
    assign s4_pd  = r_s4_der_neg ? -$signed(pddc_pkg::BASE_W'(r_s4_pd))
                                 :  $signed(pddc_pkg::BASE_W'(r_s4_pd));
    assign s4_min = !r_s4_err_nz ? '0
                  : (r_s4_err_neg ? -$signed(pddc_pkg::BASE_W'(r_min_power))
                                  :  $signed(pddc_pkg::BASE_W'(r_min_power)));
    assign s4_base = s4_min + s4_pe + s4_pd;

    // side term clamped to the side limit
    assign s4_side_mag = (r_s4_ps > pddc_pkg::TERM_W'(r_side_limit))
                       ? r_side_limit : r_s4_ps[pddc_pkg::POWER_W-1:0];
    assign s4_side     = r_s4_diff_neg ? -$signed(pddc_pkg::SIDE_W'(s4_side_mag))
                                       :  $signed(pddc_pkg::SIDE_W'(s4_side_mag));

    // ramp, held to the motor range since the output saturates there anyway
    assign s4_ramp_sum = (pddc_pkg::POWER_W + 1)'(r_min_power)
                       + (pddc_pkg::POWER_W + 1)'(r_s4_q[pddc_pkg::POWER_W-1:0]);
    assign s4_ramp     = ((r_s4_q >= pddc_pkg::Q_W'(pddc_pkg::DRIVE_MAX))
                         || (s4_ramp_sum >= (pddc_pkg::POWER_W + 1)'(pddc_pkg::DRIVE_MAX)))
                       ? pddc_pkg::POWER_W'(pddc_pkg::DRIVE_MAX)
                       : s4_ramp_sum[pddc_pkg::POWER_W-1:0];

    // stage 5 register
    always_ff @(posedge i_clk) begin
        if (r_v4 && en5) begin
            r_s5_live <= r_s4_live;
            r_s5_done <= r_s4_done;
            r_s5_tout <= r_s4_tout;
            r_s5_back <= r_s4_back;
            r_s5_base <= s4_base;
            r_s5_side <= s4_side;
            r_s5_ramp <= s4_ramp;
        end
    end

    // stage 5: split into sides and limit
    assign s5_left      = pddc_pkg::LR_W'(r_s5_base) - pddc_pkg::LR_W'(r_s5_side);
    assign s5_right     = pddc_pkg::LR_W'(r_s5_base) + pddc_pkg::LR_W'(r_s5_side);
    assign s5_left_drv  = drive_limit(s5_left, r_s5_ramp, r_s5_back);
    assign s5_right_drv = drive_limit(s5_right, r_s5_ramp, r_s5_back);

    // output register, zero word for starts and idle ticks
    always_ff @(posedge i_clk) begin
        if (r_v5 && en_out) begin
            r_out_left  <= r_s5_live ? s5_left_drv : '0;
            r_out_right <= r_s5_live ? s5_right_drv : '0;
            r_out_done  <= r_s5_done;
            r_out_tout  <= r_s5_tout;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.left_drive  = r_out_left;
    assign o_result.right_drive = r_out_right;
    assign o_result.done_res    = r_out_done;
    assign o_result.timed_out   = r_out_tout;

endmodule

`default_nettype wire

### hw/rtl/pddc_checker.sv
// port-level checks for pd_drive_distance_controller, bound to the top level
// depends on pddc_pkg and pd_drive_distance_controller_assert.svh
`default_nettype none
`include "pd_drive_distance_controller_assert.svh"

module pddc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_item_valid,
    input logic                                i_item_ready,
    input logic                                i_res_valid,
    input logic                                i_res_ready,
    input logic signed [pddc_pkg::DRIVE_W-1:0] i_left_drive,
    input logic signed [pddc_pkg::DRIVE_W-1:0] i_right_drive,
    input logic                                i_done_res,
    input logic                                i_timed_out
);

    logic [2*pddc_pkg::DRIVE_W+1:0] res_word;
    logic                           drives_in_range;
    logic                           res_stalled;
    logic                           item_blocked;
    logic                           res_timeout;

    // whole result word, for the hold check
    assign res_word = {i_left_drive, i_right_drive, i_done_res, i_timed_out};

    // drives never reach the unused negative code
    assign drives_in_range = (i_left_drive != $signed(pddc_pkg::DRIVE_W'(-128)))
                          && (i_right_drive != $signed(pddc_pkg::DRIVE_W'(-128)));

    // handshake conditions
    assign res_stalled  = i_res_valid && !i_res_ready;
    assign item_blocked = i_item_valid && !i_item_ready;
    assign res_timeout  = i_res_valid && i_timed_out;

    `PDDC_ASSERT_SAME(a_drive_range, i_clk, i_rst_n, i_res_valid, drives_in_range)
    `PDDC_ASSERT_SAME(a_timeout_ends_move, i_clk, i_rst_n, res_timeout, i_done_res)
    `PDDC_ASSERT_SAME(a_ready_when_drained, i_clk, i_rst_n, !i_res_valid, i_item_ready)
    `PDDC_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, res_stalled, i_res_valid && $stable(res_word))

    // the input is only held off while a result word waits
    `PDDC_ASSERT_SAME(a_input_blocked_by_output, i_clk, i_rst_n, item_blocked, res_stalled)

endmodule

bind pd_drive_distance_controller pddc_checker u_pddc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_item_valid  (i_item.valid),
    .i_item_ready  (i_item.ready),
    .i_res_valid   (o_result.valid),
    .i_res_ready   (o_result.ready),
    .i_left_drive  (o_result.left_drive),
    .i_right_drive (o_result.right_drive),
    .i_done_res    (o_result.done_res),
    .i_timed_out   (o_result.timed_out)
);

`default_nettype wire

### bench/tb_pd_drive_distance_controller.sv
`timescale 1ns / 100ps
// self-checking bench for the pd drive distance controller: directed and random words,
// a scoreboard class predicting each drive word, random idling on both channels
// depends on pddc_pkg and the channel interfaces in pddc_ifs.sv

module tb_pd_drive_distance_controller;

    typedef struct {
        pddc_pkg::t_op                      op;
        logic signed [pddc_pkg::DIST_W-1:0] target_distance;
        logic                               backward;
        logic signed [pddc_pkg::POS_W-1:0]  mean_position;
        logic signed [pddc_pkg::POS_W-1:0]  left_count;
        logic signed [pddc_pkg::POS_W-1:0]  right_count;
    } t_word;

    typedef struct {
        logic signed [pddc_pkg::DRIVE_W-1:0] left_drive;
        logic signed [pddc_pkg::DRIVE_W-1:0] right_drive;
        logic                                done_res;
        logic                                timed_out;
    } t_drive;

    // predicts the drive word of every accepted word and checks the words that come out
    class drive_scoreboard;
        logic [pddc_pkg::GAIN_W-1:0]    distance_gain, derivative_gain, side_gain;
        logic [pddc_pkg::TPU_W-1:0]     ticks_per_unit;
        logic [pddc_pkg::POWER_W-1:0]   min_power, side_limit;
        logic [pddc_pkg::TOL_W-1:0]     tolerance;
        logic [pddc_pkg::TIMEOUT_W-1:0] timeout_ticks;
        longint                         target_ticks, previous_error;
        bit                             have_previous, moving, going_backward;
        logic [pddc_pkg::TIMEOUT_W-1:0] tick_count;
        t_drive                         expected_drives[$];
        int                             errors;

        function new();
            distance_gain   = pddc_pkg::DISTANCE_GAIN_RST;
            derivative_gain = pddc_pkg::DERIVATIVE_GAIN_RST;
            side_gain       = pddc_pkg::SIDE_GAIN_RST;
            ticks_per_unit  = pddc_pkg::TICKS_PER_UNIT_RST;
            min_power       = pddc_pkg::MIN_POWER_RST;
            side_limit      = pddc_pkg::SIDE_LIMIT_RST;
            tolerance       = pddc_pkg::TOLERANCE_RST;
            timeout_ticks   = pddc_pkg::TIMEOUT_TICKS_RST;
            target_ticks    = 0;
            previous_error  = 0;
            have_previous   = 0;
            moving          = 0;
            going_backward  = 0;
            tick_count      = '0;
            errors          = 0;
        endfunction

        function void write_reg(pddc_pkg::t_cfg_idx idx,
                                logic [pddc_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                pddc_pkg::CFG_DISTANCE_GAIN:   distance_gain   = data;
                pddc_pkg::CFG_DERIVATIVE_GAIN: derivative_gain = data;
                pddc_pkg::CFG_SIDE_GAIN:       side_gain       = data;
                pddc_pkg::CFG_TICKS_PER_UNIT:
                    ticks_per_unit = data[pddc_pkg::TPU_W-1:0];
                pddc_pkg::CFG_MIN_POWER:
                    min_power = data[pddc_pkg::POWER_W-1:0];
                pddc_pkg::CFG_SIDE_LIMIT:
                    side_limit = data[pddc_pkg::POWER_W-1:0];
                pddc_pkg::CFG_TOLERANCE:
                    tolerance = data[pddc_pkg::TOL_W-1:0];
                pddc_pkg::CFG_TIMEOUT_TICKS:
                    timeout_ticks = data[pddc_pkg::TIMEOUT_W-1:0];
                default: ;
            endcase
        endfunction

        // q8.8 gain product, truncated toward zero
        static function longint q8_scale(logic [pddc_pkg::GAIN_W-1:0] gain, longint v);
            longint p;
            p = ((v < 0 ? -v : v) * longint'(gain)) / 256;
            return (v < 0) ? -p : p;
        endfunction

        static function longint clip_drive(longint v);
            if (v > pddc_pkg::DRIVE_MAX) return pddc_pkg::DRIVE_MAX;
            if (v < -pddc_pkg::DRIVE_MAX) return -pddc_pkg::DRIVE_MAX;
            return v;
        endfunction

        function void note_word(t_word w);
            longint pos, err, der, side, base, lft, rgt, ramp;
            bit     near, expired;
            t_drive d;
            d.left_drive  = '0;
            d.right_drive = '0;
            d.done_res    = 1'b0;
            d.timed_out   = 1'b0;
            if (w.op == pddc_pkg::OP_START) begin
                target_ticks   = longint'(w.target_distance) * longint'(ticks_per_unit);
                going_backward = w.backward;
                tick_count     = '0;
                have_previous  = 0;
                previous_error = 0;
                moving         = 1;
            end else if (moving) begin
                pos  = longint'(w.mean_position);
                err  = target_ticks - pos;
                der  = have_previous ? err - previous_error : 0;
                side = q8_scale(side_gain, longint'(w.left_count) - longint'(w.right_count));
                if (side > longint'(side_limit))
                    side = longint'(side_limit);
                else if (side < -longint'(side_limit))
                    side = -longint'(side_limit);

                // minimum power follows the sign of the error
                base = (err > 0) ? longint'(min_power)
                                 : ((err < 0) ? -longint'(min_power) : 0);
                base += q8_scale(distance_gain, err) + q8_scale(derivative_gain, der);
                lft = base - side;
                rgt = base + side;

                // ramp cap, lower side only when reversing
                ramp = longint'(min_power) + (pos < 0 ? -pos : pos) / 3;
                if (lft > ramp) lft = ramp;
                if (rgt > ramp) rgt = ramp;
                if (going_backward) begin
                    if (lft < -ramp) lft = -ramp;
                    if (rgt < -ramp) rgt = -ramp;
                end
                lft = clip_drive(lft);
                rgt = clip_drive(rgt);

                previous_error = err;
                have_previous  = 1;
                if (tick_count != '1)
                    tick_count++;
                near    = (err < 0 ? -err : err) <= longint'(tolerance);
                expired = tick_count >= timeout_ticks;
                if (near || expired)
                    moving = 0;

                d.left_drive  = lft[pddc_pkg::DRIVE_W-1:0];
                d.right_drive = rgt[pddc_pkg::DRIVE_W-1:0];
                d.done_res    = near || expired;
                d.timed_out   = !near && expired;
            end
            expected_drives.push_back(d);
        endfunction

        function void check_drive(t_drive got);
            t_drive want;
            if (expected_drives.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected drive word: left %0d right %0d done %0b timeout %0b",
                             got.left_drive, got.right_drive, got.done_res, got.timed_out);
                return;
            end
            want = expected_drives.pop_front();
            if (got.left_drive !== want.left_drive || got.right_drive !== want.right_drive ||
                got.done_res !== want.done_res || got.timed_out !== want.timed_out) begin
                errors++;
                if (errors <= 10)
                    $display({"drive mismatch at %0t: expected left %0d right %0d ",
                              "done %0b timeout %0b, got left %0d right %0d ",
                              "done %0b timeout %0b"},
                             $realtime, want.left_drive, want.right_drive, want.done_res,
                             want.timed_out, got.left_drive, got.right_drive, got.done_res,
                             got.timed_out);
            end
        endfunction

        function int pending();
            return expected_drives.size();
        endfunction

        function void close_out();
            if (expected_drives.size() > 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0d drive words never arrived", expected_drives.size());
            end
        endfunction
    endclass

    localparam int DRAIN_CYCLES = 20;

    logic i_clk;
    logic i_rst_n;

    pddc_item_if   item_bus ();
    pddc_result_if result_bus ();
    pddc_cfg_if    cfg_bus ();

    drive_scoreboard                 drive_sb;
    bit                              gaps_on;
    bit                              hold_off;
    int                              sender_calm;
    logic [pddc_pkg::CFG_DATA_W-1:0] reg_plan [8];

    pd_drive_distance_controller u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_bus),
        .i_item   (item_bus),
        .o_result (result_bus)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // hard stop
    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // result side: check accepted words, then choose next ready
    initial begin
        int     stall_left;
        int     calm_left;
        t_drive got;
        stall_left = 0;
        calm_left  = 0;
        result_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && result_bus.valid && result_bus.ready) begin
                got.left_drive  = result_bus.left_drive;
                got.right_drive = result_bus.right_drive;
                got.done_res    = result_bus.done_res;
                got.timed_out   = result_bus.timed_out;
                drive_sb.check_drive(got);
            end
            if (calm_left > 0)
                calm_left--;
            if (hold_off) begin
                result_bus.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                result_bus.ready <= 1'b0;
            end else if (gaps_on && calm_left == 0 && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 6);
                result_bus.ready <= 1'b0;
            end else begin
                result_bus.ready <= 1'b1;
                if (calm_left == 0 && $urandom_range(0, 49) == 0)
                    calm_left = $urandom_range(20, 80);
            end
        end
    end

    // offer one word until it is taken, with an occasional gap first
    task automatic push_word(input t_word w);
        int gap;
        if (gaps_on && sender_calm == 0 && $urandom_range(0, 4) == 0) begin
            item_bus.valid <= 1'b0;
            gap = $urandom_range(1, 7);
            repeat (gap) @(posedge i_clk);
        end
        if (sender_calm > 0)
            sender_calm--;
        else if ($urandom_range(0, 59) == 0)
            sender_calm = $urandom_range(15, 60);
        item_bus.valid           <= 1'b1;
        item_bus.op              <= w.op;
        item_bus.target_distance <= w.target_distance;
        item_bus.backward        <= w.backward;
        item_bus.mean_position   <= w.mean_position;
        item_bus.left_count      <= w.left_count;
        item_bus.right_count     <= w.right_count;
        do @(posedge i_clk); while (!item_bus.ready);
        drive_sb.note_word(w);
    endtask

    task automatic send_start(input logic signed [pddc_pkg::DIST_W-1:0] move_dist,
                              input logic back);
        t_word w;
        w.op              = pddc_pkg::OP_START;
        w.target_distance = move_dist;
        w.backward        = back;
        w.mean_position   = pddc_pkg::POS_W'($urandom);
        w.left_count      = pddc_pkg::POS_W'($urandom);
        w.right_count     = pddc_pkg::POS_W'($urandom);
        push_word(w);
    endtask

    task automatic send_tick(input logic signed [pddc_pkg::POS_W-1:0] pos,
                             input logic signed [pddc_pkg::POS_W-1:0] left,
                             input logic signed [pddc_pkg::POS_W-1:0] right);
        t_word w;
        w.op              = pddc_pkg::OP_TICK;
        w.target_distance = pddc_pkg::DIST_W'($urandom);
        w.backward        = 1'($urandom);
        w.mean_position   = pos;
        w.left_count      = left;
        w.right_count     = right;
        push_word(w);
    endtask

    // drop valid so that the last word is not taken twice
    task automatic release_item();
        item_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // end any move, let the pipe drain, then write every register from the plan
    task automatic apply_settings();
        pddc_pkg::t_cfg_idx idx;
        if (drive_sb.moving)
            send_tick(pddc_pkg::POS_W'(drive_sb.target_ticks),
                      pddc_pkg::POS_W'($urandom), pddc_pkg::POS_W'($urandom));
        release_item();
        while (drive_sb.pending() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        idx = idx.first();
        do begin
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= idx;
            cfg_bus.data  <= reg_plan[idx];
            do @(posedge i_clk); while (!cfg_bus.ready);
            drive_sb.write_reg(idx, reg_plan[idx]);
            idx = idx.next();
        end while (idx != idx.first());
        cfg_bus.valid <= 1'b0;
    endtask

    // register value with random bits above its width now and then
    function automatic logic [pddc_pkg::CFG_DATA_W-1:0] with_junk(int unsigned value,
                                                                  int width);
        logic [pddc_pkg::CFG_DATA_W-1:0] junk;
        junk = $urandom_range(0, 1) ? pddc_pkg::CFG_DATA_W'($urandom << width) : '0;
        return junk | pddc_pkg::CFG_DATA_W'(value);
    endfunction

    function automatic void plan_random();
        reg_plan[pddc_pkg::CFG_DISTANCE_GAIN]   = pddc_pkg::CFG_DATA_W'($urandom_range(0, 600));
        reg_plan[pddc_pkg::CFG_DERIVATIVE_GAIN] =
            pddc_pkg::CFG_DATA_W'($urandom_range(0, 1500));
        reg_plan[pddc_pkg::CFG_SIDE_GAIN]       = pddc_pkg::CFG_DATA_W'($urandom_range(0, 600));
        reg_plan[pddc_pkg::CFG_TICKS_PER_UNIT]  =
            with_junk($urandom_range(0, 60), pddc_pkg::TPU_W);
        reg_plan[pddc_pkg::CFG_MIN_POWER]       =
            with_junk($urandom_range(0, 127), pddc_pkg::POWER_W);
        reg_plan[pddc_pkg::CFG_SIDE_LIMIT]      =
            with_junk($urandom_range(0, 127), pddc_pkg::POWER_W);
        reg_plan[pddc_pkg::CFG_TOLERANCE]       =
            with_junk($urandom_range(0, 80), pddc_pkg::TOL_W);
        reg_plan[pddc_pkg::CFG_TIMEOUT_TICKS]   =
            with_junk($urandom_range(0, 7) == 0 ? $urandom_range(1, 1023) :
                                                  $urandom_range(1, 40),
                      pddc_pkg::TIMEOUT_W);
    endfunction

    function automatic void plan_reset_values();
        reg_plan[pddc_pkg::CFG_DISTANCE_GAIN]   = pddc_pkg::DISTANCE_GAIN_RST;
        reg_plan[pddc_pkg::CFG_DERIVATIVE_GAIN] = pddc_pkg::DERIVATIVE_GAIN_RST;
        reg_plan[pddc_pkg::CFG_SIDE_GAIN]       = pddc_pkg::SIDE_GAIN_RST;
        reg_plan[pddc_pkg::CFG_TICKS_PER_UNIT]  =
            pddc_pkg::CFG_DATA_W'(pddc_pkg::TICKS_PER_UNIT_RST);
        reg_plan[pddc_pkg::CFG_MIN_POWER]       =
            pddc_pkg::CFG_DATA_W'(pddc_pkg::MIN_POWER_RST);
        reg_plan[pddc_pkg::CFG_SIDE_LIMIT]      =
            pddc_pkg::CFG_DATA_W'(pddc_pkg::SIDE_LIMIT_RST);
        reg_plan[pddc_pkg::CFG_TOLERANCE]       =
            pddc_pkg::CFG_DATA_W'(pddc_pkg::TOLERANCE_RST);
        reg_plan[pddc_pkg::CFG_TIMEOUT_TICKS]   =
            pddc_pkg::CFG_DATA_W'(pddc_pkg::TIMEOUT_TICKS_RST);
    endfunction

    // mostly whole moves: start, then ticks closing in on the target with some
    // overshoot; the rest is random noise and abandoned moves
    task automatic run_moves(input int n_words);
        int                                 sent;
        int                                 steps;
        int                                 diff;
        longint                             err;
        longint                             pos;
        logic signed [pddc_pkg::DIST_W-1:0] move_dist;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1)) begin
                    send_start(pddc_pkg::DIST_W'($urandom), 1'($urandom));
                    sent++;
                end else begin
                    if (drive_sb.moving)
                        sent++;
                    send_tick(pddc_pkg::POS_W'($urandom), pddc_pkg::POS_W'($urandom),
                              pddc_pkg::POS_W'($urandom));
                end
            end else begin
                if ($urandom_range(0, 7) == 0)
                    move_dist = pddc_pkg::DIST_W'($urandom);
                else
                    move_dist = pddc_pkg::DIST_W'(int'($urandom_range(0, 120)) - 60);
                send_start(move_dist, move_dist < 0 ? ($urandom_range(0, 7) != 0) :
                                                      ($urandom_range(0, 7) == 0));
                sent++;
                err   = drive_sb.target_ticks;
                steps = 0;
                while (drive_sb.moving && steps < 40) begin
                    pos  = drive_sb.target_ticks - err;
                    diff = int'($urandom_range(0, 60)) - 30;
                    send_tick(pddc_pkg::POS_W'(pos), pddc_pkg::POS_W'(pos + diff),
                              pddc_pkg::POS_W'(pos - diff));
                    sent++;
                    steps++;
                    err = err * longint'($urandom_range(30, 85)) / 100
                          + longint'($urandom_range(0, 10)) - 5;
                    if ($urandom_range(0, 9) == 0)
                        err = -err;
                    else if (steps > 5 && $urandom_range(0, 5) == 0)
                        err = longint'($urandom_range(0, drive_sb.tolerance));
                end
            end
        end
    endtask

    // main sequence
    initial begin
        drive_sb    = new();
        gaps_on     = 1'b1;
        sender_calm = 0;
        hold_off <= 1'b0;
        i_rst_n  <= 1'b0;
        item_bus.valid           <= 1'b0;
        item_bus.op              <= pddc_pkg::OP_START;
        item_bus.target_distance <= '0;
        item_bus.backward        <= 1'b0;
        item_bus.mean_position   <= '0;
        item_bus.left_count      <= '0;
        item_bus.right_count     <= '0;
        cfg_bus.valid            <= 1'b0;
        cfg_bus.index            <= pddc_pkg::CFG_DISTANCE_GAIN;
        cfg_bus.data             <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words on reset settings: tick while idle, field extremes,
        // first tick without derivative, zero error
        send_tick(24'h7FFFFF, 24'h7FFFFF, 24'h800000);
        send_start(11'sd1023, 1'b0);
        send_tick(24'h000000, 24'h7FFFFF, 24'h800000);
        send_tick(24'h800000, 24'h800000, 24'h7FFFFF);
        send_tick(24'sd28644, 24'sd5, 24'sd9);
        send_start(11'h400, 1'b1);
        send_tick(24'h7FFFFF, 24'h000000, 24'h000000);
        send_tick(-24'sd28662, -24'sd28600, -24'sd28700);
        send_start(11'sd0, 1'b1);
        send_tick(24'sd100, 24'sd5, 24'sd3);
        send_tick(-24'sd100, -24'sd7, 24'sd40);
        send_tick(24'sd0, 24'sd0, 24'sd0);

        // zero timeout ends the move on its first tick
        plan_reset_values();
        reg_plan[pddc_pkg::CFG_TIMEOUT_TICKS] = '0;
        apply_settings();
        send_start(11'sd500, 1'b0);
        send_tick(24'sd0, 24'sd1, 24'sd1);

        // near and expired on the same tick, then expired alone
        reg_plan[pddc_pkg::CFG_TOLERANCE]     = 16'd4095;
        reg_plan[pddc_pkg::CFG_TIMEOUT_TICKS] = 16'd1;
        apply_settings();
        send_start(11'sd10, 1'b0);
        send_tick(24'sd3, 24'sd2, 24'sd2);
        send_start(11'h400, 1'b1);
        send_tick(24'sd0, 24'h7FFFFF, 24'h000001);

        // every register at its top value, upper bits set too
        foreach (reg_plan[i])
            reg_plan[i] = '1;
        apply_settings();
        run_moves(235);

        // every register at zero
        foreach (reg_plan[i])
            reg_plan[i] = '0;
        apply_settings();
        run_moves(235);

        plan_reset_values();
        apply_settings();
        run_moves(235);

        // long hold-off on the result side while words keep coming
        plan_random();
        apply_settings();
        fork
            begin
                hold_off <= 1'b1;
                repeat (120) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            begin
                run_moves(60);
                release_item();
            end
        join
        run_moves(175);

        repeat (3) begin
            plan_random();
            apply_settings();
            run_moves(235);
        end

        // last stretch without idling
        plan_random();
        apply_settings();
        gaps_on = 1'b0;
        run_moves(235);

        release_item();
        while (drive_sb.pending() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        drive_sb.close_out();
        if (drive_sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
